// ===== hw/rtl/upx_pkg.sv =====
// Shared types, constants and coefficient table of the 4x polyphase upsampler.
package upx_pkg;

  localparam int TAPS            = 12;
  localparam int COEF_BITS       = 14;
  localparam int COEF_SHIFT      = 13;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int ACC_GUARD       = 4;
  localparam int FIFO_DEPTH      = 8;
  localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS   = $clog2(FIFO_DEPTH + 1);
  localparam int PHASES          = 4;

  localparam logic [1:0] RATIO_2X = 2'd1;
  localparam logic [1:0] RATIO_4X = 2'd2;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  localparam coef_t COEF_TAB [PHASES][TAPS] = '{
    '{-14'sd68,   14'sd122,  -14'sd218,  14'sd390,  -14'sd838,  14'sd7964,
      14'sd1125,  -14'sd487, 14'sd272,   -14'sd161, 14'sd90,    14'sd14},
    '{-14'sd155,  14'sd271,  -14'sd477,  14'sd832,  -14'sd1641, 14'sd6388,
      14'sd3810,  -14'sd1364, 14'sd730,  -14'sd424, 14'sd240,   -14'sd239},
    '{-14'sd239,  14'sd240,  -14'sd424,  14'sd730,  -14'sd1364, 14'sd3810,
      14'sd6388,  -14'sd1641, 14'sd832,  -14'sd477, 14'sd271,   -14'sd155},
    '{14'sd14,    14'sd90,   -14'sd161,  14'sd272,  -14'sd487,  14'sd1125,
      14'sd7964,  -14'sd838, 14'sd390,   -14'sd218, 14'sd122,   -14'sd68}
  };

  typedef struct packed {
    logic       valid;
    logic [1:0] phase;
    logic       last;
  } tag_t;

endpackage

// ===== hw/rtl/upx_cell.sv =====
// One tap cell: holds one window sample and adds its product to the passing partial sum.
module upx_cell import upx_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = SAMPLE_BITS_DEF + COEF_BITS + ACC_GUARD,
  parameter int TAP_IDX     = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] sample_nbr,
  output logic signed [SAMPLE_BITS-1:0] sample,
  input  tag_t                          tag_in,
  input  logic signed [ACC_BITS-1:0]    psum_in,
  output tag_t                          tag_out,
  output logic signed [ACC_BITS-1:0]    psum_out
);

  coef_t                                    coef;
  logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod;

  assign coef = COEF_TAB[tag_in.phase][TAP_IDX];
  assign prod = sample * coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample  <= '0;
      tag_out <= '0;
    end else begin
      if (load) begin
        sample <= sample_nbr;
      end
      tag_out <= tag_in;
    end
    psum_out <= psum_in + ACC_BITS'(prod);
  end

endmodule

// ===== hw/rtl/upx_round_sat.sv =====
// Output stage: rounds a finished sum to the sample scale and clamps it to the output range.
module upx_round_sat import upx_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = SAMPLE_BITS_DEF + COEF_BITS + ACC_GUARD
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tag_t                          tag_in,
  input  logic signed [ACC_BITS-1:0]    psum_in,
  output tag_t                          tag_out,
  output logic signed [SAMPLE_BITS+1:0] result
);

  localparam int OUT_BITS = SAMPLE_BITS + 2;
  localparam logic signed [ACC_BITS-1:0] OUT_MAX =
    ACC_BITS'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_BITS-1:0] OUT_MIN = -OUT_MAX - ACC_BITS'(1);
  localparam logic signed [ACC_BITS-1:0] HALF_LSB = ACC_BITS'(64'sd1 <<< (COEF_SHIFT - 1));

  logic signed [ACC_BITS-1:0] biased;
  logic signed [ACC_BITS-1:0] scaled;
  logic signed [ACC_BITS-1:0] clamped;

  always_comb begin
    biased = psum_in + HALF_LSB;
    scaled = biased >>> COEF_SHIFT;
    if (scaled > OUT_MAX) begin
      clamped = OUT_MAX;
    end else if (scaled < OUT_MIN) begin
      clamped = OUT_MIN;
    end else begin
      clamped = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
    result <= clamped[OUT_BITS-1:0];
  end

endmodule

// ===== hw/rtl/polyphase_upsampler_4x.sv =====
// Top level of the 4x polyphase true-peak upsampler: sequencer, tap cell chain and output queue.
//
// Each input beat on in_valid/in_stall carries one signed sample. The block answers with
// four output beats (phases 0, 1, 2, 3) when ratio_log2 selects 4x, or two beats (phases 0
// and 2) in 2x mode; last marks the final beat of each run. A write on cfg_wr_en loads
// ratio_log2, which takes effect at the next accepted input.
// The window of twelve samples lives in a chain of twelve tap cells. Partial sums move one
// cell per cycle, and one phase enters the chain per cycle; one rounding stage and an
// eight-entry output queue follow. A new input is taken only after the last result of the
// previous one has left the rounding stage.
// Reset clears the sample window, the queue and the sequencer, and sets 4x mode.
// When the receiver stalls, results wait in the queue; a new input is still taken while
// no more than four results wait, otherwise in_stall stays high.
module polyphase_upsampler_4x import upx_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS+1:0] sample_out,
  output logic [1:0]                    phase_index,
  output logic                          last
);

  localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + ACC_GUARD;
  localparam int OUT_BITS = SAMPLE_BITS + 2;

  logic [1:0]                   ratio_log2;
  logic                         busy;
  logic                         issuing;
  logic                         mode_four;
  logic [1:0]                   issue_k;
  logic                         accept;
  logic                         out_take;
  tag_t                         issue_tag;

  logic signed [SAMPLE_BITS-1:0] samples [TAPS];
  logic signed [ACC_BITS-1:0]    psums   [TAPS+1];
  tag_t                          tags    [TAPS+1];

  tag_t                          res_tag;
  logic signed [OUT_BITS-1:0]    res_data;

  logic signed [OUT_BITS-1:0]    fifo_data [FIFO_DEPTH];
  tag_t                          fifo_tag  [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0]      wr_ptr;
  logic [FIFO_PTR_BITS-1:0]      rd_ptr;
  logic [FIFO_CNT_BITS-1:0]      count;

  assign in_stall = busy || (count > FIFO_CNT_BITS'(PHASES));
  assign accept   = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign out_take  = out_valid && !out_stall;

  always_comb begin
    issue_tag.valid = issuing;
    issue_tag.phase = mode_four ? issue_k : {issue_k[0], 1'b0};
    issue_tag.last  = mode_four ? (issue_k == 2'd3) : (issue_k == 2'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_log2 <= RATIO_4X;
      busy       <= 1'b0;
      issuing    <= 1'b0;
      mode_four  <= 1'b1;
      issue_k    <= '0;
    end else begin
      if (cfg_wr_en) begin
        ratio_log2 <= cfg_wr_data;
      end
      if (accept) begin
        busy      <= 1'b1;
        issuing   <= 1'b1;
        issue_k   <= '0;
        mode_four <= (ratio_log2 >= RATIO_4X);
      end else if (issuing) begin
        issue_k <= issue_k + 2'd1;
        if (issue_tag.last) begin
          issuing <= 1'b0;
        end
      end
      if (res_tag.valid && res_tag.last) begin
        busy <= 1'b0;
      end
    end
  end

  assign tags[0]  = issue_tag;
  assign psums[0] = '0;

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] nbr;
    if (i == TAPS - 1) begin : g_head
      assign nbr = sample_in;
    end else begin : g_body
      assign nbr = samples[i+1];
    end
    upx_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_BITS    (ACC_BITS),
      .TAP_IDX     (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .load       (accept),
      .sample_nbr (nbr),
      .sample     (samples[i]),
      .tag_in     (tags[i]),
      .psum_in    (psums[i]),
      .tag_out    (tags[i+1]),
      .psum_out   (psums[i+1])
    );
  end

  upx_round_sat #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS)
  ) u_round (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tags[TAPS]),
    .psum_in (psums[TAPS]),
    .tag_out (res_tag),
    .result  (res_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_tag.valid) begin
        wr_ptr <= wr_ptr + FIFO_PTR_BITS'(1);
      end
      if (out_take) begin
        rd_ptr <= rd_ptr + FIFO_PTR_BITS'(1);
      end
      if (res_tag.valid && !out_take) begin
        count <= count + FIFO_CNT_BITS'(1);
      end else if (!res_tag.valid && out_take) begin
        count <= count - FIFO_CNT_BITS'(1);
      end
    end
    if (res_tag.valid) begin
      fifo_data[wr_ptr] <= res_data;
      fifo_tag[wr_ptr]  <= res_tag;
    end
  end

  assign sample_out  = fifo_data[rd_ptr];
  assign phase_index = fifo_tag[rd_ptr].phase;
  assign last        = fifo_tag[rd_ptr].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("Output queue holds more beats than its depth.");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_tag.valid |-> (count < FIFO_CNT_BITS'(FIFO_DEPTH)) || out_take)
    else $error("Result written into a full output queue.");

  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    (res_tag.valid || issuing) |-> busy)
    else $error("Chain activity outside of an accepted beat.");

  a_issue_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> issuing && (issue_k == 2'd0))
    else $error("Phase issue did not start after an input beat.");

endmodule

// ===== sim/tb_polyphase_upsampler_4x.sv =====
// Self-checking testbench for the 4x/2x polyphase true-peak upsampler.
`timescale 1ns / 1ps

module tb_polyphase_upsampler_4x;
  import upx_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int OB = SB + 2;
  localparam int HIST = TAPS - 1;
  localparam int SETTLE_CYCLES = 24;
  localparam int QUIET_LIMIT = 3000;
  localparam logic [1:0] RATIO_BELOW_2X = 2'd0;
  localparam logic [1:0] RATIO_ABOVE_4X = 2'd3;
  localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

  typedef struct {
    logic signed [OB-1:0] value;
    logic [1:0]           phase;
    logic                 last;
  } upsample_beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [1:0]           cfg_wr_data = 2'd0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [SB-1:0] sample_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [OB-1:0] sample_out;
  logic [1:0]           phase_index;
  logic                 last;

  int tap_coef [4][TAPS] = '{
    '{-68, 122, -218, 390, -838, 7964, 1125, -487, 272, -161, 90, 14},
    '{-155, 271, -477, 832, -1641, 6388, 3810, -1364, 730, -424, 240, -239},
    '{-239, 240, -424, 730, -1364, 3810, 6388, -1641, 832, -477, 271, -155},
    '{14, 90, -161, 272, -487, 1125, 7964, -838, 390, -218, 122, -68}
  };

  logic signed [SB-1:0] past_samples [HIST];
  logic [1:0]           ratio_model;
  upsample_beat_t       pending_outputs [$];
  int                   error_count = 0;
  int                   quiet_cycles = 0;
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;

  wire in_beat  = in_valid && !in_stall;
  wire out_beat = out_valid && !out_stall;

  polyphase_upsampler_4x dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .phase_index(phase_index),
    .last       (last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic signed [OB-1:0] phase_sum(input logic signed [SB-1:0] newest,
                                                     input int ph);
    longint acc;
    longint rounded;
    longint hi;
    acc = longint'(newest) * tap_coef[ph][TAPS-1];
    for (int i = 0; i < HIST; i++) begin
      acc += longint'(past_samples[i]) * tap_coef[ph][i];
    end
    rounded = (acc + (64'sd1 <<< (COEF_SHIFT - 1))) >>> COEF_SHIFT;
    hi = (64'sd1 <<< (OB - 1)) - 1;
    if (rounded > hi) rounded = hi;
    if (rounded < -hi - 1) rounded = -hi - 1;
    return rounded[OB-1:0];
  endfunction

  task automatic predict_interp(input logic signed [SB-1:0] s);
    upsample_beat_t b;
    int n;
    n = (ratio_model >= RATIO_4X) ? 4 : 2;
    for (int k = 0; k < n; k++) begin
      b.phase = (n == 4) ? k[1:0] : 2'(k * 2);
      b.value = phase_sum(s, int'(b.phase));
      b.last = (k == n - 1);
      pending_outputs.push_back(b);
    end
    for (int i = 0; i < HIST - 1; i++) past_samples[i] = past_samples[i+1];
    past_samples[HIST-1] = s;
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Model state follows the configuration and input beats seen at each edge.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST; i++) past_samples[i] = '0;
      ratio_model = RATIO_4X;
    end else begin
      if (cfg_wr_en) ratio_model = cfg_wr_data;
      if (in_beat) predict_interp(sample_in);
    end
  end

  always @(posedge clk) begin
    upsample_beat_t want;
    if (!rst && out_beat) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected beat value=%0d phase=%0d last=%0d",
                                  sample_out, phase_index, last));
      end else begin
        want = pending_outputs.pop_front();
        if (sample_out !== want.value || phase_index !== want.phase || last !== want.last) begin
          report_mismatch($sformatf("got value=%0d phase=%0d last=%0d, want %0d/%0d/%0d",
                                    sample_out, phase_index, last,
                                    want.value, want.phase, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || in_beat || out_beat) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic signed [SB-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ratio(input logic [1:0] r);
    wait_all_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [SB-1:0] random_sample();
    logic signed [SB-1:0] s;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: s = SAMPLE_MAX;
          1: s = SAMPLE_MIN;
          2: s = '0;
          default: s = '1;
        endcase
      end
      1: s = SB'($signed($urandom_range(8192)) - 4096);
      default: s = SB'($urandom);
    endcase
    return s;
  endfunction

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  // Runs at the reset ratio: impulse response, rounding ties, full-scale swings.
  task automatic test_directed();
    set_idling(0, 0);
    send_sample(SAMPLE_MAX);
    repeat (HIST) send_sample('0);
    send_sample(SB'(2048));
    send_sample(-SB'(2048));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('1);
    send_sample(SB'(1));
    send_sample(SB'(24'h555555));
    send_sample(SB'(24'haaaaaa));
  endtask

  // Every ratio code, including the two out-of-range ones that saturate.
  task automatic test_ratio_codes();
    logic [1:0] codes [4];
    codes = '{RATIO_BELOW_2X, RATIO_2X, RATIO_ABOVE_4X, RATIO_4X};
    set_idling(36, 36);
    foreach (codes[c]) begin
      write_ratio(codes[c]);
      repeat (12) send_sample(random_sample());
    end
  endtask

  task automatic test_pause_until_drained();
    set_idling(0, 76);
    repeat (10) send_sample(random_sample());
    wait_all_results();
    repeat (10) send_sample(random_sample());
  endtask

  task automatic test_random_traffic(input logic [1:0] r, input int send_pct,
                                     input int recv_pct);
    write_ratio(r);
    set_idling(send_pct, recv_pct);
    repeat (75) send_sample(random_sample());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_ratio_codes();
    test_pause_until_drained();
    test_random_traffic(RATIO_4X, 0, 0);
    test_random_traffic(RATIO_2X, 76, 0);
    test_random_traffic(RATIO_4X, 0, 76);
    test_random_traffic(RATIO_2X, 36, 36);
    wait_all_results();
    if (error_count == 0 && pending_outputs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
